/* rtl/core/rpm_pkg.sv */
// Shared types, widths and codes for the range predicate merger.
// Depends on nothing; every other file of the block imports it.
package rpm_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int PROP_WIDTH  = 16;
    localparam int STR_WIDTH   = 4;
    localparam int REL_WIDTH   = 3;

    // Input beat layout in tdata, lowest bit first.
    localparam int IN_PROP_LSB  = 0;
    localparam int IN_STR_LSB   = IN_PROP_LSB + PROP_WIDTH;
    localparam int IN_REL_LSB   = IN_STR_LSB + STR_WIDTH;
    localparam int IN_VAL_LSB   = IN_REL_LSB + REL_WIDTH;
    localparam int IN_USED_W    = IN_VAL_LSB + VALUE_WIDTH;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output beat layout in tdata, lowest bit first.
    localparam int OUT_CONSUMED = 0;
    localparam int OUT_FINAL    = 1;
    localparam int OUT_OK       = 2;
    localparam int OUT_HAS_EQ   = 3;
    localparam int OUT_EQ_LSB   = 4;
    localparam int OUT_HAS_UP   = OUT_EQ_LSB + VALUE_WIDTH;
    localparam int OUT_UP_LSB   = OUT_HAS_UP + 1;
    localparam int OUT_UP_INCL  = OUT_UP_LSB + VALUE_WIDTH;
    localparam int OUT_HAS_LO   = OUT_UP_INCL + 1;
    localparam int OUT_LO_LSB   = OUT_HAS_LO + 1;
    localparam int OUT_LO_INCL  = OUT_LO_LSB + VALUE_WIDTH;
    localparam int OUT_USED_W   = OUT_LO_INCL + 1;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // Relation codes; anything above REL_GE is an unmerged relation.
    localparam logic [REL_WIDTH-1:0] REL_EQ = 3'd0;
    localparam logic [REL_WIDTH-1:0] REL_LT = 3'd1;
    localparam logic [REL_WIDTH-1:0] REL_LE = 3'd2;
    localparam logic [REL_WIDTH-1:0] REL_GT = 3'd3;
    localparam logic [REL_WIDTH-1:0] REL_GE = 3'd4;

    typedef struct packed {
        logic [PROP_WIDTH-1:0]         property_id;
        logic [STR_WIDTH-1:0]          strength;
        logic [REL_WIDTH-1:0]          relation;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last;
    } t_item;

    // Merged constraint set, as held between beats and handed to the resolver.
    typedef struct packed {
        logic                          eq_valid;
        logic signed [VALUE_WIDTH-1:0] eq_val;
        logic                          up_valid;
        logic signed [VALUE_WIDTH-1:0] up_val;
        logic                          up_incl;
        logic                          lo_valid;
        logic signed [VALUE_WIDTH-1:0] lo_val;
        logic                          lo_incl;
        logic                          conflict;
    } t_bounds;

    typedef struct packed {
        logic                          consumed;
        logic                          final_res;
        logic                          ok;
        logic                          has_equal;
        logic signed [VALUE_WIDTH-1:0] equal_value;
        logic                          has_upper;
        logic signed [VALUE_WIDTH-1:0] upper_value;
        logic                          upper_inclusive;
        logic                          has_lower;
        logic signed [VALUE_WIDTH-1:0] lower_value;
        logic                          lower_inclusive;
    } t_result;

    localparam t_bounds BOUNDS_CLEAR = '0;

endpackage

/* rtl/core/rpm_merge.sv */
// Constraint state and the per-beat merge of one criterion into it.
// Depends on rpm_pkg.
module rpm_merge
    import rpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_item                 i_item,
    input  logic [PROP_WIDTH-1:0] i_target,
    output logic                  o_consumed,
    output t_bounds               o_snap
);

    t_bounds r_st;
    t_bounds n_st;
    logic    match;
    logic    used;
    logic    v_lt_up;
    logic    v_eq_up;
    logic    v_gt_lo;
    logic    v_eq_lo;

    assign match = !r_st.conflict && (i_item.strength == '0)
                   && (i_item.property_id == i_target);

    assign v_lt_up = i_item.value < r_st.up_val;
    assign v_eq_up = i_item.value == r_st.up_val;
    assign v_gt_lo = i_item.value > r_st.lo_val;
    assign v_eq_lo = i_item.value == r_st.lo_val;

    always_comb begin
        n_st = r_st;
        used = 1'b0;
        if (match) begin
            case (i_item.relation)
                REL_EQ: begin
                    if (r_st.eq_valid && (r_st.eq_val != i_item.value)) begin
                        n_st.conflict = 1'b1;
                    end else begin
                        used          = 1'b1;
                        n_st.eq_valid = 1'b1;
                        n_st.eq_val   = i_item.value;
                    end
                end
                REL_LT: begin
                    used = 1'b1;
                    // A strict bound at the same value is tighter than an inclusive one.
                    if (!r_st.up_valid || v_lt_up || (r_st.up_incl && v_eq_up)) begin
                        n_st.up_valid = 1'b1;
                        n_st.up_val   = i_item.value;
                        n_st.up_incl  = 1'b0;
                    end
                end
                REL_LE: begin
                    used = 1'b1;
                    if (!r_st.up_valid || v_lt_up) begin
                        n_st.up_valid = 1'b1;
                        n_st.up_val   = i_item.value;
                        n_st.up_incl  = 1'b1;
                    end
                end
                REL_GT: begin
                    used = 1'b1;
                    if (!r_st.lo_valid || v_gt_lo || (r_st.lo_incl && v_eq_lo)) begin
                        n_st.lo_valid = 1'b1;
                        n_st.lo_val   = i_item.value;
                        n_st.lo_incl  = 1'b0;
                    end
                end
                REL_GE: begin
                    used = 1'b1;
                    if (!r_st.lo_valid || v_gt_lo) begin
                        n_st.lo_valid = 1'b1;
                        n_st.lo_val   = i_item.value;
                        n_st.lo_incl  = 1'b1;
                    end
                end
                default: begin
                    used = 1'b0;
                end
            endcase
        end
    end

    assign o_consumed = used;
    assign o_snap     = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BOUNDS_CLEAR;
        end else if (i_en) begin
            r_st <= i_item.last ? BOUNDS_CLEAR : n_st;
        end
    end

endmodule

/* rtl/core/rpm_resolve.sv */
// Final consistency check of a merged constraint set and result formatting.
// Depends on rpm_pkg.
module rpm_resolve
    import rpm_pkg::*;
(
    input  t_bounds i_snap,
    input  logic    i_last,
    input  logic    i_consumed,
    output t_result o_res
);

    logic                          ok;
    logic                          he;
    logic                          hu;
    logic                          hl;
    logic signed [VALUE_WIDTH-1:0] ev;

    always_comb begin
        ok = !i_snap.conflict;
        he = i_snap.eq_valid;
        hu = i_snap.up_valid;
        hl = i_snap.lo_valid;
        ev = i_snap.eq_val;
        if (ok && he) begin
            if (hu && (i_snap.up_incl ? (i_snap.up_val < ev) : (i_snap.up_val <= ev))) begin
                ok = 1'b0;
            end
            if (hl && (i_snap.lo_incl ? (i_snap.lo_val > ev) : (i_snap.lo_val >= ev))) begin
                ok = 1'b0;
            end
            hu = 1'b0;
            hl = 1'b0;
        end else if (ok && hu && hl) begin
            if (i_snap.up_incl && i_snap.lo_incl) begin
                if (i_snap.up_val < i_snap.lo_val) begin
                    ok = 1'b0;
                end
                // Touching inclusive bounds pin the value down to a single point.
                if (i_snap.up_val == i_snap.lo_val) begin
                    he = 1'b1;
                    ev = i_snap.up_val;
                    hu = 1'b0;
                    hl = 1'b0;
                end
            end else if (i_snap.lo_val >= i_snap.up_val) begin
                ok = 1'b0;
            end
        end

        o_res          = '0;
        o_res.consumed = i_consumed;
        if (i_last) begin
            o_res.final_res = 1'b1;
            if (ok) begin
                o_res.ok = 1'b1;
                if (he) begin
                    o_res.has_equal   = 1'b1;
                    o_res.equal_value = ev;
                end
                if (hu) begin
                    o_res.has_upper       = 1'b1;
                    o_res.upper_value     = i_snap.up_val;
                    o_res.upper_inclusive = i_snap.up_incl;
                end
                if (hl) begin
                    o_res.has_lower       = 1'b1;
                    o_res.lower_value     = i_snap.lo_val;
                    o_res.lower_inclusive = i_snap.lo_incl;
                end
            end
        end
    end

endmodule

/* rtl/core/range_predicate_merger.sv */
// Top level of the range predicate merger: handshakes, pipeline registers,
// configuration register. Depends on rpm_pkg, rpm_merge and rpm_resolve.
//
//   Channel     | Direction | Carries
//   ------------+-----------+--------------------------------------------------
//   s_axis      | in        | one criterion per beat, tlast ends the set
//   m_axis      | out       | one result per criterion, final fields on last
//   cfg         | in        | target property id, write-only
//
// Every criterion gives exactly one result beat. The block sustains one beat per
// cycle while m_axis does not stall; an accepted criterion is loaded into the input
// register, then merged into the snapshot register, and the checked result is then
// loaded into the output register, from which it is offered on m_axis.
// The merge of a beat into the held constraints is a single compare
// and select per bound, so back-to-back beats on the same set need no bubbles.
// Reset is synchronous and active low; it clears the stage valid flags, the
// merged constraints and the target property. A stall on m_axis holds the
// output beat and backs up through the stages until s_axis tready falls.
module range_predicate_merger
    import rpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: property_id[15:0], strength[19:16], relation[22:20],
    //        value[54:23], zero padding above.
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,   // last_criterion

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: consumed[0], final_res[1], ok[2], has_equal[3], equal_value[35:4],
    //        has_upper[36], upper_value[68:37], upper_inclusive[69],
    //        has_lower[70], lower_value[102:71], lower_inclusive[103].
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,

    input  logic                  i_cfg_we,
    input  logic [PROP_WIDTH-1:0] i_cfg_wdata       // target_property
);

    logic [PROP_WIDTH-1:0] r_target_prop;

    // Stage 1: accepted criterion.
    logic    r_s1_valid;
    t_item   r_s1_item;
    // Stage 2: merged snapshot of the constraint set after this criterion.
    logic    r_s2_valid;
    logic    r_s2_consumed;
    logic    r_s2_last;
    t_bounds r_s2_snap;
    // Stage 3: output beat.
    logic    r_out_valid;
    t_result r_out;

    logic    out_adv;
    logic    s2_adv;
    logic    s1_adv;
    logic    merge_en;
    logic    mrg_consumed;
    t_bounds mrg_snap;
    t_result res;
    t_item   in_item;

    assign out_adv  = !r_out_valid || i_m_axis_tready;
    assign s2_adv   = !r_s2_valid || out_adv;
    assign s1_adv   = !r_s1_valid || s2_adv;
    assign merge_en = r_s1_valid && s2_adv;

    assign o_s_axis_tready = s1_adv;

    always_comb begin
        in_item.property_id = i_s_axis_tdata[IN_STR_LSB-1:IN_PROP_LSB];
        in_item.strength    = i_s_axis_tdata[IN_REL_LSB-1:IN_STR_LSB];
        in_item.relation    = i_s_axis_tdata[IN_VAL_LSB-1:IN_REL_LSB];
        in_item.value       = i_s_axis_tdata[IN_USED_W-1:IN_VAL_LSB];
        in_item.last        = i_s_axis_tlast;
    end

    // Users change target only with pipeline empty; unenforced, read directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_prop <= '0;
        end else if (i_cfg_we) begin
            r_target_prop <= i_cfg_wdata;
        end
    end

    rpm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (merge_en),
        .i_item     (r_s1_item),
        .i_target   (r_target_prop),
        .o_consumed (mrg_consumed),
        .o_snap     (mrg_snap)
    );

    rpm_resolve u_resolve (
        .i_snap     (r_s2_snap),
        .i_last     (r_s2_last),
        .i_consumed (r_s2_consumed),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_s_axis_tvalid) begin
            r_s1_item <= in_item;
        end
        if (merge_en) begin
            r_s2_consumed <= mrg_consumed;
            r_s2_last     <= r_s1_item.last;
            r_s2_snap     <= mrg_snap;
        end
        if (out_adv && r_s2_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata                                = '0;
        o_m_axis_tdata[OUT_CONSUMED]                  = r_out.consumed;
        o_m_axis_tdata[OUT_FINAL]                     = r_out.final_res;
        o_m_axis_tdata[OUT_OK]                        = r_out.ok;
        o_m_axis_tdata[OUT_HAS_EQ]                    = r_out.has_equal;
        o_m_axis_tdata[OUT_HAS_UP-1:OUT_EQ_LSB]       = r_out.equal_value;
        o_m_axis_tdata[OUT_HAS_UP]                    = r_out.has_upper;
        o_m_axis_tdata[OUT_UP_INCL-1:OUT_UP_LSB]      = r_out.upper_value;
        o_m_axis_tdata[OUT_UP_INCL]                   = r_out.upper_inclusive;
        o_m_axis_tdata[OUT_HAS_LO]                    = r_out.has_lower;
        o_m_axis_tdata[OUT_LO_INCL-1:OUT_LO_LSB]      = r_out.lower_value;
        o_m_axis_tdata[OUT_LO_INCL]                   = r_out.lower_inclusive;
    end

endmodule

/* rtl/core/rpm_checker.sv */
// Port-level assertions for the range predicate merger, bound to the top level.
// Depends on rpm_pkg and range_predicate_merger.
module rpm_checker
    import rpm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    // No result beat is offered in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result beat offered straight after reset");

    // A stalled result beat stays offered and unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    // A beat that does not close a set carries only the consumed flag.
    a_nonfinal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[OUT_FINAL]
        |-> o_m_axis_tdata[OUT_DATA_W-1:OUT_OK] == '0)
        else $error("non-final result carries merged fields");

    // A contradiction reports no equality and no bounds.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_FINAL] && !o_m_axis_tdata[OUT_OK]
        |-> o_m_axis_tdata[OUT_DATA_W-1:OUT_HAS_EQ] == '0)
        else $error("contradiction reported with constraint fields");

    // An equality is always reported alone.
    a_eq_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_HAS_EQ]
        |-> !o_m_axis_tdata[OUT_HAS_UP] && !o_m_axis_tdata[OUT_HAS_LO])
        else $error("equality reported together with a bound");

endmodule

bind range_predicate_merger rpm_checker u_rpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
